// ===== rtl/core/bfa_pkg.sv =====
// Shared types and constants for the best-fit allocator.
package bfa_pkg;

    localparam int RECORDS_DEF   = 1024;
    localparam int ADDR_BITS_DEF = 31;
    localparam int AMT_W         = ADDR_BITS_DEF;
    localparam int REQ_W         = $clog2(RECORDS_DEF + 1);

    localparam logic [1:0] ST_GRANT = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_EXHST = 2'd2;

    typedef struct packed {
        logic             mode;
        logic [AMT_W-1:0] alloc_amount;
        logic [REQ_W-1:0] request_to_free;
    } t_in;

    typedef struct packed {
        logic [1:0]       status;
        logic [AMT_W-1:0] start_address;
    } t_out;

endpackage

// ===== rtl/core/bfa_ram.sv =====
// Generic single-port-write, single-read RAM with registered read.
module bfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/core/best_fit_allocator_coalescing.sv =====
// Top level of the best-fit allocator with coalescing of free blocks.
// Every transaction is accepted while the block is idle. An allocate scans
// the free table one entry per cycle and keeps busy high through the scan
// and the table update; busy does not rise when the allocate is refused at
// once for a zero amount, an empty table or used-up numbers. A free reads
// its record, then scans the table up to twice, once for the block above and
// once for the block below, and removes each merged neighbor; the table
// holds at most RECORDS + 1 entries. A write to memory_units re-initializes
// the allocator and starts a clearing pass over the request records, during
// which busy is high. The same pass runs after reset. Results appear for one
// cycle on o_valid and cannot be held off. The free table is an unordered
// array in one RAM (count register gives its fill); records live in a second
// RAM, live when size is nonzero.
module best_fit_allocator_coalescing #(
    parameter int RECORDS   = bfa_pkg::RECORDS_DEF,
    parameter int ADDR_BITS = bfa_pkg::ADDR_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  bfa_pkg::t_in      i_item,
    output logic              o_valid,
    output bfa_pkg::t_out     o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [1:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    localparam int TD   = RECORDS + 1;
    localparam int TA   = $clog2(TD);
    localparam int RA   = $clog2(RECORDS);
    localparam int CW   = $clog2(TD + 1);
    localparam int NW   = $clog2(RECORDS + 1);
    localparam int EW   = 2 * ADDR_BITS;

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_ASCN = 4'd2;
    localparam logic [3:0] S_FRS  = 4'd3;   // restart scan from slot 0
    localparam logic [3:0] S_ALST = 4'd4;
    localparam logic [3:0] S_FRD  = 4'd5;
    localparam logic [3:0] S_FCHK = 4'd6;
    localparam logic [3:0] S_FSCN = 4'd7;
    localparam logic [3:0] S_RMV  = 4'd8;
    localparam logic [3:0] S_RMW  = 4'd9;
    localparam logic [3:0] S_ADD  = 4'd10;

    typedef bfa_pkg::t_out t_out_h;

    logic [3:0] r_st, n_st;
    logic [ADDR_BITS-1:0] r_units;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_reqc;
    logic [RA:0]   r_clr;
    logic [TA-1:0] r_idx;        // slot being issued
    logic          r_rv;         // read data valid for r_ridx
    logic [TA-1:0] r_ridx;
    logic [ADDR_BITS-1:0] r_amt;
    logic [NW-1:0] r_num;
    logic          r_found;
    logic [TA-1:0] r_best;
    logic [ADDR_BITS-1:0] r_bst, r_bsz;
    logic [ADDR_BITS-1:0] r_fst, r_fsz;    // block under free / merge
    logic          r_pass;                  // 0: right neighbor, 1: left
    logic [TA-1:0] r_rm;                    // slot to remove
    logic          r_next;                  // after remove: 0 add, 1 next pass
    logic          r_ov;
    t_out_h        r_out;

    // free table RAM
    logic          ft_we;
    logic [TA-1:0] ft_wa, ft_ra;
    logic [EW-1:0] ft_wd, ft_rd;
    // record RAM
    logic          rc_we;
    logic [RA-1:0] rc_wa, rc_ra;
    logic [EW-1:0] rc_wd, rc_rd;

    bfa_ram #(.WIDTH(EW), .DEPTH(TD)) u_ft (
        .i_clk(i_clk), .i_we(ft_we), .i_waddr(ft_wa), .i_wdata(ft_wd),
        .i_raddr(ft_ra), .o_rdata(ft_rd));
    bfa_ram #(.WIDTH(EW), .DEPTH(RECORDS)) u_rc (
        .i_clk(i_clk), .i_we(rc_we), .i_waddr(rc_wa), .i_wdata(rc_wd),
        .i_raddr(rc_ra), .o_rdata(rc_rd));

    logic [ADDR_BITS-1:0] e_st, e_sz;
    assign e_st = ft_rd[EW-1:ADDR_BITS];
    assign e_sz = ft_rd[ADDR_BITS-1:0];

    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr == 2'd0);
    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? 32'(r_units) : 32'd0;

    logic acc;
    assign busy = (r_st != S_IDLE);
    assign acc  = start && !busy;

    logic [RA-1:0] vic_a;
    assign vic_a = RA'(i_item.request_to_free - 1'b1);
    logic vic_ok;
    assign vic_ok = (i_item.request_to_free != '0) &&
                    (32'(i_item.request_to_free) <= 32'(RECORDS));

    // allocate that goes on to scan the table
    logic alloc_scan;
    assign alloc_scan = acc && !i_item.mode && (r_reqc != NW'(RECORDS)) &&
                        (i_item.alloc_amount != '0) && (r_cnt != '0);

    // initial table entry written in the first cycle of the clearing pass
    logic init_wr;
    assign init_wr = (r_st == S_CLR) && (r_clr == '0);

    // scan read index
    logic last_rd;   // r_ridx is last valid slot
    assign last_rd = ({1'b0, r_ridx} + 1'b1) >= (CW+1)'(r_cnt);

    logic better;
    assign better = (e_sz >= r_amt) && (!r_found || e_sz < r_bsz ||
                    (e_sz == r_bsz && e_st < r_bst));

    always_comb begin
        n_st  = r_st;
        ft_we = 1'b0; ft_wa = '0; ft_wd = '0; ft_ra = r_idx;
        rc_we = 1'b0; rc_wa = '0; rc_wd = '0; rc_ra = vic_a;
        case (r_st)
            S_CLR: begin
                rc_we = 1'b1; rc_wa = r_clr[RA-1:0];
                if (init_wr) begin
                    ft_we = 1'b1; ft_wa = '0; ft_wd = {r_fst, r_fsz};
                end
                if (r_clr == (RA+1)'(RECORDS - 1)) n_st = S_IDLE;
            end
            S_IDLE: begin
                ft_ra = '0;
                if (acc) begin
                    if (i_item.mode) n_st = vic_ok ? S_FRD : S_IDLE;
                    else if (alloc_scan) n_st = S_ASCN;
                    else n_st = S_IDLE;
                end
            end
            S_ASCN: if (r_rv && last_rd) n_st = S_ALST;
            S_ALST: begin
                if (!r_found) n_st = S_IDLE;
                else begin
                    rc_we = 1'b1; rc_wa = RA'(r_num - 1'b1);
                    rc_wd = {r_bst, r_amt};
                    n_st = S_RMV;
                end
            end
            S_FRD: begin
                rc_ra = RA'(r_num);   // victim slot held in r_num
                n_st = S_FCHK;
            end
            S_FCHK: begin
                if (rc_rd[ADDR_BITS-1:0] == '0) n_st = S_IDLE;
                else begin
                    rc_we = 1'b1; rc_wa = RA'(r_num); // victim slot held in r_num
                    n_st = (r_cnt == '0) ? S_ADD : S_FSCN;
                end
            end
            S_FSCN: begin
                if (r_rv && ((r_pass == 1'b0 && e_st == r_fst + r_fsz) ||
                             (r_pass == 1'b1 && e_st + e_sz == r_fst)))
                    n_st = S_RMV;
                else if (r_rv && last_rd) begin
                    if (r_pass == 1'b0) begin
                        ft_ra = '0;
                        n_st = S_FSCN;
                    end else begin
                        n_st = S_ADD;
                    end
                end
            end
            S_RMV: begin
                ft_ra = TA'(r_cnt - 1'b1);
                n_st = S_RMW;
            end
            S_RMW: begin
                ft_ra = TA'(r_cnt - 1'b1);
                n_st = S_RMW;
                if (r_ov) begin
                    ft_we = 1'b1; ft_wa = r_rm; ft_wd = ft_rd;
                    if (!r_next) n_st = S_ADD;
                    else n_st = (r_cnt == CW'(1)) ? S_ADD : S_FRS;
                end
            end
            S_FRS: begin
                ft_ra = '0;
                n_st = S_FSCN;
            end
            S_ADD: begin
                if (r_fsz != '0) begin
                    ft_we = 1'b1; ft_wa = TA'(r_cnt); ft_wd = {r_fst, r_fsz};
                end
                n_st = S_IDLE;
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_wr) begin
            r_st   <= S_CLR;
            r_clr  <= '0;
            r_reqc <= '0;
            r_cnt  <= CW'(1);
            r_fst  <= ADDR_BITS'(1);
            r_rv   <= 1'b0;
            r_ov   <= 1'b0;
            r_idx  <= '0;
            o_valid <= 1'b0;
            if (!i_rst_n) begin
                r_units <= ADDR_BITS'(1);
                r_fsz   <= ADDR_BITS'(1);
            end else begin
                r_units <= pwdata[ADDR_BITS-1:0];
                r_fsz   <= pwdata[ADDR_BITS-1:0];
            end
        end else begin
            r_st    <= n_st;
            o_valid <= 1'b0;
            r_rv    <= 1'b0;
            r_ov    <= 1'b0;
            case (r_st)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    // table entry 0 holds all memory as one block; zero memory leaves the table empty
                    if (r_clr == '0 && r_fsz == '0) r_cnt <= '0;
                end
                S_IDLE: begin
                    r_found <= 1'b0; r_pass <= 1'b0;
                    r_idx   <= alloc_scan ? TA'(1) : '0;
                    if (acc) begin
                        r_amt  <= ADDR_BITS'(i_item.alloc_amount);
                        if (i_item.mode) r_num <= NW'(vic_a);
                        else r_num <= (r_reqc == NW'(RECORDS)) ? '0 : r_reqc + 1'b1;
                        if (r_reqc != NW'(RECORDS)) r_reqc <= r_reqc + 1'b1;
                        if (!i_item.mode) begin
                            if (r_reqc == NW'(RECORDS)) begin
                                o_valid <= 1'b1;
                                r_out <= '{status: bfa_pkg::ST_EXHST, start_address: '0};
                            end else if (i_item.alloc_amount == '0 || r_cnt == '0) begin
                                o_valid <= 1'b1;
                                r_out <= '{status: bfa_pkg::ST_NOFIT, start_address: '0};
                            end else begin
                                r_rv <= 1'b1; r_ridx <= '0;
                            end
                        end
                    end
                end
                S_ASCN: begin
                    if (r_rv) begin
                        if (better) begin
                            r_found <= 1'b1; r_best <= r_ridx;
                            r_bst <= e_st; r_bsz <= e_sz;
                        end
                        if (!last_rd) begin
                            r_rv <= 1'b1; r_ridx <= r_idx; r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                S_ALST: begin
                    o_valid <= 1'b1;
                    if (!r_found)
                        r_out <= '{status: bfa_pkg::ST_NOFIT, start_address: '0};
                    else begin
                        r_out <= '{status: bfa_pkg::ST_GRANT,
                                   start_address: bfa_pkg::AMT_W'(r_bst)};
                        r_rm <= r_best; r_next <= 1'b0;
                        r_fst <= r_bst + r_amt; r_fsz <= r_bsz - r_amt;
                    end
                end
                S_FCHK: begin
                    r_fst <= rc_rd[EW-1:ADDR_BITS];
                    r_fsz <= rc_rd[ADDR_BITS-1:0];
                    r_rv <= (r_cnt != '0); r_ridx <= '0; r_idx <= TA'(1);
                    r_pass <= 1'b0;
                end
                S_FSCN: begin
                    if (r_rv) begin
                        if ((r_pass == 1'b0 && e_st == r_fst + r_fsz) ||
                            (r_pass == 1'b1 && e_st + e_sz == r_fst)) begin
                            if (r_pass) r_fst <= e_st;
                            r_fsz <= r_fsz + e_sz;
                            r_rm <= r_ridx; r_next <= ~r_pass;
                            r_pass <= 1'b1;
                        end else if (!last_rd) begin
                            r_rv <= 1'b1; r_ridx <= r_idx; r_idx <= r_idx + 1'b1;
                        end else if (r_pass == 1'b0) begin
                            r_pass <= 1'b1;
                            r_rv <= 1'b1; r_ridx <= '0; r_idx <= TA'(1);
                        end
                    end
                end
                S_RMV: r_ov <= 1'b1;
                S_RMW: if (r_ov) r_cnt <= r_cnt - 1'b1;
                // moved entry is written by now, so slot 0 reads fresh data
                S_FRS: begin
                    r_rv <= 1'b1; r_ridx <= '0; r_idx <= TA'(1);
                end
                S_ADD: if (r_fsz != '0) r_cnt <= r_cnt + 1'b1;
                default: ;
            endcase
        end
    end

    assign o_result = r_out;

    // a result leaves the block only while idle or starting the table update
    a_out_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_st == S_IDLE || r_st == S_RMV)) else $error("stray result");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(TD)) else $error("free table overflow");
    a_busy_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_item.mode) |=> !o_valid) else $error("result for free");
endmodule

// ===== tb/sv/best_fit_allocator_coalescing_tb.sv =====
// Self-checking testbench for the best-fit allocator with coalescing.
module best_fit_allocator_coalescing_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          NREC       = bfa_pkg::RECORDS_DEF;
    localparam int          TBL_DEPTH  = NREC + 1;
    localparam logic        MODE_ALLOC = 1'b0;
    localparam logic        MODE_FREE  = 1'b1;
    localparam logic [1:0]  REG_MEMORY = 2'd0;   // memory_units at byte address 0
    localparam longint      AMASK      = (64'd1 << bfa_pkg::AMT_W) - 1;
    // Slowest quiet stretch: clearing pass or two full table scans plus the
    // longest sender gap; taken several times over.
    localparam int          WATCHDOG   = 20000;

    typedef struct {
        longint unsigned base;
        longint unsigned len;
    } t_span;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          start = 1'b0;
    logic          busy;
    bfa_pkg::t_in  i_item = '0;
    logic          o_valid;
    bfa_pkg::t_out o_result;
    logic          psel = 1'b0;
    logic          penable = 1'b0;
    logic          pwrite = 1'b0;
    logic [1:0]    paddr = '0;
    logic [31:0]   pwdata = '0;
    logic [31:0]   prdata;
    logic          pready;

    best_fit_allocator_coalescing dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_valid (o_valid),
        .o_result(o_result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #6 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Allocator mirror: free list, request records and number counter
    // ---------------------------------------------------------------
    longint unsigned mem_units;
    t_span           free_list [TBL_DEPTH];
    int              free_fill;
    t_span           grants [NREC+1];
    int              req_taken;
    int              live_reqs[$];       // numbers of granted, unreleased requests
    bfa_pkg::t_out   pending_grants[$];  // expected results, oldest first

    int  errors;
    int  items_sent;
    int  results_seen;
    int  grants_seen;
    int  frees_sent;
    bit  idling_on;

    function automatic void span_insert(longint unsigned b, longint unsigned l);
        if (l == 0 || free_fill >= TBL_DEPTH) return;
        free_list[free_fill].base = b;
        free_list[free_fill].len  = l;
        free_fill++;
    endfunction

    function automatic void span_drop(int slot);
        if (slot >= free_fill) return;
        free_fill--;
        free_list[slot] = free_list[free_fill];
    endfunction

    function automatic void mirror_restart(longint unsigned units);
        mem_units = units & AMASK;
        free_fill = 0;
        req_taken = 0;
        for (int k = 0; k <= NREC; k++) grants[k] = '{0, 0};
        live_reqs.delete();
        span_insert(1, mem_units);
    endfunction

    // Update the mirror with one accepted transaction; queue its result, if any.
    function automatic void mirror_apply(bfa_pkg::t_in it);
        int              num;
        int              best;
        bit              found;
        longint unsigned amt;
        longint unsigned b;
        longint unsigned l;
        bfa_pkg::t_out   res;
        num   = 0;
        best  = 0;
        found = 0;
        amt   = it.alloc_amount;
        if (req_taken < NREC) begin
            req_taken++;
            num = req_taken;
        end
        if (it.mode == MODE_ALLOC) begin
            res = '{status: bfa_pkg::ST_GRANT, start_address: '0};
            if (num == 0) begin
                res.status = bfa_pkg::ST_EXHST;
            end else begin
                if (amt != 0) begin
                    for (int k = 0; k < free_fill; k++) begin
                        if (free_list[k].len < amt) continue;
                        if (!found || free_list[k].len < free_list[best].len ||
                            (free_list[k].len == free_list[best].len &&
                             free_list[k].base < free_list[best].base)) begin
                            best  = k;
                            found = 1;
                        end
                    end
                end
                if (!found) begin
                    res.status = bfa_pkg::ST_NOFIT;
                end else begin
                    b = free_list[best].base;
                    l = free_list[best].len;
                    span_drop(best);
                    if (amt < l) span_insert(b + amt, l - amt);
                    grants[num] = '{b, amt};
                    live_reqs.push_back(num);
                    res.start_address = b[bfa_pkg::AMT_W-1:0];
                end
            end
            pending_grants.push_back(res);
            return;
        end
        // release path: unknown or dead numbers are ignored
        if (it.request_to_free == 0 || it.request_to_free > NREC) return;
        if (grants[it.request_to_free].len == 0) return;
        b = grants[it.request_to_free].base;
        l = grants[it.request_to_free].len;
        grants[it.request_to_free] = '{0, 0};
        foreach (live_reqs[k]) begin
            if (live_reqs[k] == it.request_to_free) begin
                live_reqs.delete(k);
                break;
            end
        end
        // upper neighbor, then lower neighbor
        for (int k = 0; k < free_fill; k++) begin
            if (free_list[k].base == b + l) begin
                l += free_list[k].len;
                span_drop(k);
                break;
            end
        end
        for (int k = 0; k < free_fill; k++) begin
            if (free_list[k].base + free_list[k].len == b) begin
                b = free_list[k].base;
                l += free_list[k].len;
                span_drop(k);
                break;
            end
        end
        span_insert(b, l);
    endfunction

    // ---------------------------------------------------------------
    // Result checker: every strobe must match the oldest expectation
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        bfa_pkg::t_out want;
        if (i_rst_n && o_valid) begin
            results_seen++;
            if (pending_grants.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: status=%0d start=%0d",
                             o_result.status, o_result.start_address);
            end else begin
                want = pending_grants.pop_front();
                if (want.status == bfa_pkg::ST_GRANT) grants_seen++;
                if (o_result.status !== want.status ||
                    o_result.start_address !== want.start_address) begin
                    errors++;
                    if (errors <= 10)
                        $display({"result mismatch: exp status=%0d start=%0d,",
                                  " got status=%0d start=%0d"},
                                 want.status, want.start_address,
                                 o_result.status, o_result.start_address);
                end
            end
        end
    end

    // Watchdog: cycles with no transaction on any port
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || (psel && penable) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG) begin
            $display("best_fit_allocator_coalescing: mismatch");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    task automatic sender_gap();
        int n;
        n = $urandom_range(1, 18);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // One transaction: hold start until the block takes it.
    task automatic issue_item(input logic md, input logic [bfa_pkg::AMT_W-1:0] amt,
                              input logic [bfa_pkg::REQ_W-1:0] req);
        bfa_pkg::t_in it;
        it.mode            = md;
        it.alloc_amount    = amt;
        it.request_to_free = req;
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        mirror_apply(it);
        items_sent++;
        if (md == MODE_FREE) frees_sent++;
        if (idling_on && $urandom_range(0, 4) == 0) sender_gap();
    endtask

    task automatic alloc(input logic [bfa_pkg::AMT_W-1:0] amt);
        issue_item(MODE_ALLOC, amt, bfa_pkg::REQ_W'($urandom));
    endtask

    task automatic release_req(input logic [bfa_pkg::REQ_W-1:0] req);
        issue_item(MODE_FREE, bfa_pkg::AMT_W'($urandom), req);
    endtask

    // Wait out all results and any release still in progress.
    task automatic drain();
        start <= 1'b0;
        while (pending_grants.size() != 0) @(posedge i_clk);
        do @(posedge i_clk); while (busy);
        repeat (4) @(posedge i_clk);
    endtask

    // Register write (setup + access), then read back; block must be idle.
    task automatic set_memory_units(input logic [31:0] value);
        drain();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= REG_MEMORY;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        mirror_restart(value);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[bfa_pkg::AMT_W-1:0] !== mem_units[bfa_pkg::AMT_W-1:0]) begin
            errors++;
            if (errors <= 10)
                $display("register readback: exp %0d got %0d", mem_units,
                         prdata[bfa_pkg::AMT_W-1:0]);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // Reset memory of one unit: grant, no fit, zero amount, bad releases.
    task automatic test_reset_state();
        alloc(1);
        alloc(1);
        alloc(0);
        release_req(1);
        alloc(2);
        alloc(1);
        release_req(0);
        release_req(11'd1024);
        release_req(11'd2047);
        release_req(3);
    endtask

    task automatic test_zero_memory();
        set_memory_units(32'd0);
        alloc(1);
        alloc(0);
        alloc('1);
    endtask

    // Largest memory, largest request, top bit of the register write masked off.
    task automatic test_extremes();
        set_memory_units(32'hFFFF_FFFF);
        alloc('1);
        alloc(1);
        release_req(1);
        alloc(1);
        alloc(31'h7FFF_FFFE);
        alloc(31'h4000_0000);
    endtask

    // Equal-size holes pick the lowest address; release merges on both sides.
    task automatic test_ties_and_merge();
        set_memory_units(32'd100);
        alloc(10);
        alloc(5);
        alloc(10);
        alloc(5);
        alloc(10);
        release_req(4);
        release_req(2);
        alloc(5);          // both 5-unit holes fit: lower one wins
        release_req(8);
        release_req(3);    // joins holes below and above
        alloc(20);
        release_req(8);    // already released: ignored
    endtask

    // Random traffic against one memory size; mostly well-formed alloc/free pairs.
    task automatic test_random_phase(input logic [31:0] units, input int count,
                                     input bit hold_midway);
        longint unsigned cap;
        int              pick;
        logic [bfa_pkg::AMT_W-1:0] amt;
        set_memory_units(units);
        cap = (mem_units / 6) + 1;
        for (int n = 0; n < count; n++) begin
            if (hold_midway && n == count / 2) drain();
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                amt = bfa_pkg::AMT_W'($urandom_range(1,
                          (cap > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : 32'(cap)));
                if ($urandom_range(0, 3) == 0) amt = bfa_pkg::AMT_W'($urandom_range(1, 4));
                alloc(amt);
            end else if (pick < 55) begin
                alloc(bfa_pkg::AMT_W'($urandom));
            end else if (pick < 57) begin
                alloc(0);
            end else if (pick < 90 && live_reqs.size() != 0) begin
                release_req(bfa_pkg::REQ_W'(
                    live_reqs[$urandom_range(0, live_reqs.size() - 1)]));
            end else begin
                release_req(bfa_pkg::REQ_W'($urandom));
            end
        end
    endtask

    initial begin
        errors       = 0;
        items_sent   = 0;
        results_seen = 0;
        grants_seen  = 0;
        frees_sent   = 0;
        idling_on    = 1;
        mirror_restart(1);
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_zero_memory();
        test_extremes();
        test_ties_and_merge();
        test_random_phase($urandom_range(1, 64), 140, 1);
        test_random_phase(32'd1000, 140, 0);
        test_random_phase(32'h0010_0000, 130, 0);
        idling_on = 0;   // back-to-back at the end
        test_random_phase(32'hFFFF_FFFF, 130, 0);

        drain();
        repeat (20) @(posedge i_clk);
        $display("covered %0d transactions (%0d releases), %0d results, %0d grants",
                 items_sent, frees_sent, results_seen, grants_seen);
        $display("memory sizes 0, 1, 100, random, 1000, 2^20, 2^31-1; %0d errors", errors);
        if (errors == 0 && pending_grants.size() == 0)
            $display("best_fit_allocator_coalescing: match");
        else
            $display("best_fit_allocator_coalescing: mismatch");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/bfa_pkg.sv
rtl/core/bfa_ram.sv
rtl/core/best_fit_allocator_coalescing.sv
tb/sv/best_fit_allocator_coalescing_tb.sv
